/* src/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the mesh route-compute block.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // Mesh size and the coordinate width that follows from it.
  localparam int MESH_DIM = 32;
  localparam int COORD_W  = $clog2(MESH_DIM);
  localparam int LOAD_W   = 8;
  localparam int SEED_W   = 32;

  // Linear congruential step used by the randomized mode.
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // Routing algorithm selected by the mode register.
  typedef enum logic [2:0] {
    MODE_XY             = 3'd0,
    MODE_YX             = 3'd1,
    MODE_WEST_FIRST     = 3'd2,
    MODE_NORTH_LAST     = 3'd3,
    MODE_NEGATIVE_FIRST = 3'd4,
    MODE_ODD_EVEN       = 3'd5,
    MODE_ADAPTIVE       = 3'd6,
    MODE_RANDOMIZED     = 3'd7
  } route_mode_t;

  // Output port codes.
  typedef enum logic [2:0] {
    PORT_LOCAL = 3'd0,
    PORT_EAST  = 3'd1,
    PORT_WEST  = 3'd2,
    PORT_SOUTH = 3'd3,
    PORT_NORTH = 3'd4
  } port_t;

  // One route request as held in the input register.
  typedef struct packed {
    logic [COORD_W-1:0] here_x;
    logic [COORD_W-1:0] here_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [LOAD_W-1:0]  east_load;
    logic [LOAD_W-1:0]  west_load;
    logic [LOAD_W-1:0]  south_load;
    logic [LOAD_W-1:0]  north_load;
    logic [SEED_W-1:0]  rand_seed;
  } req_t;

endpackage

/* src/mrc_if.sv */
// ----------------------------------------------------------------------------
// mrc interfaces
// Valid/ready channels for requests, responses and the mode register write.
// ----------------------------------------------------------------------------

// Route request channel.
interface mrc_req_if;
  import mrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] here_x;
  logic [COORD_W-1:0] here_y;
  logic [COORD_W-1:0] target_x;
  logic [COORD_W-1:0] target_y;
  logic [LOAD_W-1:0]  east_load;
  logic [LOAD_W-1:0]  west_load;
  logic [LOAD_W-1:0]  south_load;
  logic [LOAD_W-1:0]  north_load;
  logic [SEED_W-1:0]  rand_seed;

  modport source (
    output valid, here_x, here_y, target_x, target_y,
           east_load, west_load, south_load, north_load, rand_seed,
    input  ready
  );
  modport sink (
    input  valid, here_x, here_y, target_x, target_y,
           east_load, west_load, south_load, north_load, rand_seed,
    output ready
  );
endinterface

// Route response channel.
interface mrc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_port;

  modport source (output valid, out_port, input ready);
  modport sink (input valid, out_port, output ready);
endinterface

// Mode register write channel.
interface mrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/mesh_route_compute.sv */
// ----------------------------------------------------------------------------
// mesh_route_compute
// Route computation for one router of a two-dimensional mesh.
// ----------------------------------------------------------------------------
// Each request carries the router's own coordinates, the destination, the
// loads of the four output channels and a seed, and yields one output port
// (local, east, west, south or north) chosen by the algorithm in the mode
// register. The block is a two-register pipeline: a request can be accepted
// every cycle while the response channel takes results, and its result is
// offered on the response channel from the result register, with the
// input register and the result register each advancing whenever the stage
// after them has room. The mode register should only be written while no
// request is in flight; its write channel is always ready.
module mesh_route_compute (
  input  logic      clk,
  input  logic      rst,
  mrc_cfg_if.sink   cfg,
  mrc_req_if.sink   req,
  mrc_rsp_if.source rsp
);
  import mrc_pkg::*;

  route_mode_t route_mode;
  logic        stage_valid;
  req_t        stage_req;
  logic        stage_ready;
  port_t       stage_port;

  // Mode register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_mode <= MODE_XY;
    end else if (cfg.valid && cfg.ready) begin
      route_mode <= route_mode_t'(cfg.data);
    end
  end

  // Input register.
  mrc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .stage_valid (stage_valid),
    .stage_req   (stage_req),
    .stage_ready (stage_ready)
  );

  // Port selection.
  mrc_route_logic u_route_logic (
    .cur_req (stage_req),
    .mode    (route_mode),
    .port    (stage_port)
  );

  // Result register.
  mrc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (stage_valid),
    .res_port  (stage_port),
    .res_ready (stage_ready),
    .rsp       (rsp)
  );

endmodule

/* src/mrc_in_stage.sv */
// ----------------------------------------------------------------------------
// mrc_in_stage
// Input register: captures one request per cycle while downstream has room.
// ----------------------------------------------------------------------------
module mrc_in_stage (
  input  logic          clk,
  input  logic          rst,
  mrc_req_if.sink       req,
  output logic          stage_valid,
  output mrc_pkg::req_t stage_req,
  input  logic          stage_ready
);
  import mrc_pkg::*;

  logic stage_valid_next;

  // The register can load when it is empty or its content moves on this cycle.
  assign req.ready = !stage_valid || stage_ready;

  // Occupancy of the input register.
  always_comb begin
    stage_valid_next = stage_valid;
    if (req.ready) begin
      stage_valid_next = req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_req.here_x     <= req.here_x;
      stage_req.here_y     <= req.here_y;
      stage_req.target_x   <= req.target_x;
      stage_req.target_y   <= req.target_y;
      stage_req.east_load  <= req.east_load;
      stage_req.west_load  <= req.west_load;
      stage_req.south_load <= req.south_load;
      stage_req.north_load <= req.north_load;
      stage_req.rand_seed  <= req.rand_seed;
    end
  end

endmodule

/* src/mrc_route_logic.sv */
// ----------------------------------------------------------------------------
// mrc_route_logic
// Combinational port selection for all routing modes.
// ----------------------------------------------------------------------------
module mrc_route_logic (
  input  mrc_pkg::req_t       cur_req,
  input  mrc_pkg::route_mode_t mode,
  output mrc_pkg::port_t      port
);
  import mrc_pkg::*;

  logic  need_x;
  logic  need_y;
  logic  go_east;
  logic  go_west;
  logic  go_south;
  logic  go_north;
  logic  both;
  port_t port_x;
  port_t port_y;
  port_t dim_order;
  logic [LOAD_W-1:0] load_x;
  logic [LOAD_W-1:0] load_y;
  logic  lcg_bit0;

  // Direction flags from the coordinate compares.
  assign need_x   = (cur_req.here_x != cur_req.target_x);
  assign need_y   = (cur_req.here_y != cur_req.target_y);
  assign go_east  = (cur_req.target_x > cur_req.here_x);
  assign go_west  = (cur_req.target_x < cur_req.here_x);
  assign go_south = (cur_req.target_y > cur_req.here_y);
  assign go_north = (cur_req.target_y < cur_req.here_y);
  assign both     = need_x && need_y;
  assign port_x   = go_east ? PORT_EAST : PORT_WEST;
  assign port_y   = go_south ? PORT_SOUTH : PORT_NORTH;

  // When only one dimension is needed, that one is taken (X preferred).
  assign dim_order = need_x ? port_x : port_y;

  // Loads of the two candidate channels for the adaptive mode.
  assign load_x = go_east ? cur_req.east_load : cur_req.west_load;
  assign load_y = go_south ? cur_req.south_load : cur_req.north_load;

  // Bit 0 of one LCG step depends only on bit 0 of the seed and of the
  // constants, since the carries of the product and the sum only move up.
  assign lcg_bit0 = (cur_req.rand_seed[0] & LCG_MUL[0]) ^ LCG_ADD[0];

  // Mode selection.
  always_comb begin
    port = PORT_LOCAL;
    if (need_x || need_y) begin
      case (mode)
        MODE_YX: begin
          port = need_y ? port_y : port_x;
        end
        MODE_NEGATIVE_FIRST: begin
          if (go_west) begin
            port = PORT_WEST;
          end else if (go_north) begin
            port = PORT_NORTH;
          end else if (go_east) begin
            port = PORT_EAST;
          end else begin
            port = PORT_SOUTH;
          end
        end
        MODE_ADAPTIVE: begin
          if (both) begin
            port = (load_x <= load_y) ? port_x : port_y;
          end else begin
            port = dim_order;
          end
        end
        MODE_RANDOMIZED: begin
          if (both) begin
            port = lcg_bit0 ? port_x : port_y;
          end else begin
            port = dim_order;
          end
        end
        default: begin
          // XY order; west-first, north-last and odd-even resolve to it.
          port = dim_order;
        end
      endcase
    end
  end

endmodule

/* src/mrc_out_stage.sv */
// ----------------------------------------------------------------------------
// mrc_out_stage
// Result register: holds the chosen port until the consumer takes it.
// ----------------------------------------------------------------------------
module mrc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  input  mrc_pkg::port_t res_port,
  output logic           res_ready,
  mrc_rsp_if.source      rsp
);
  import mrc_pkg::*;

  logic  out_valid;
  logic  out_valid_next;
  port_t out_port;

  // Load when empty or when the held result leaves this cycle.
  assign res_ready = !out_valid || rsp.ready;

  always_comb begin
    out_valid_next = out_valid;
    if (res_ready) begin
      out_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_port <= res_port;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.out_port = out_port;

endmodule

/* dv/mesh_route_compute_tb.sv */
// ----------------------------------------------------------------------------
// mesh_route_compute_tb
// Self-checking testbench for the mesh route-compute block. Route requests
// are driven on the request channel, and an independent route predictor
// computes the port that each accepted transaction should produce. Responses
// are compared in order against those predictions. The mode register is
// stepped through every algorithm. A short directed pass covers the corners,
// then random traffic follows with random gaps and back-pressure on both
// channels, and a last pass sends back-to-back traffic with neither.
// ----------------------------------------------------------------------------
module mesh_route_compute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrc_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int IDLE_PERCENT  = 32;
  localparam int ITEMS_PER_MODE = 80;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MESH_DIM - 1);

  logic clk;
  logic rst;

  mrc_cfg_if cfg_ch ();
  mrc_req_if req_ch ();
  mrc_rsp_if rsp_ch ();

  mesh_route_compute DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted ports for transactions in flight, and the mode the block holds.
  port_t       expected_ports[$];
  route_mode_t active_mode;
  int          mismatch_count;
  int          cycle_count;
  bit          steady_traffic;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Port that the block should pick for one request under a given mode.
  function automatic port_t predict_port(route_mode_t mode, req_t r);
    logic        need_x;
    logic        need_y;
    port_t       step_x;
    port_t       step_y;
    logic [7:0]  load_x;
    logic [7:0]  load_y;
    logic [31:0] lcg;
    need_x = (r.here_x != r.target_x);
    need_y = (r.here_y != r.target_y);
    step_x = (r.target_x > r.here_x) ? PORT_EAST : PORT_WEST;
    step_y = (r.target_y > r.here_y) ? PORT_SOUTH : PORT_NORTH;
    if (!need_x && !need_y) begin
      return PORT_LOCAL;
    end
    case (mode)
      MODE_YX: begin
        return need_y ? step_y : step_x;
      end
      MODE_NEGATIVE_FIRST: begin
        if (r.target_x < r.here_x) return PORT_WEST;
        if (r.target_y < r.here_y) return PORT_NORTH;
        if (r.target_x > r.here_x) return PORT_EAST;
        return PORT_SOUTH;
      end
      MODE_ADAPTIVE: begin
        if (need_x && need_y) begin
          load_x = (r.target_x > r.here_x) ? r.east_load : r.west_load;
          load_y = (r.target_y > r.here_y) ? r.south_load : r.north_load;
          return (load_x <= load_y) ? step_x : step_y;
        end
        return need_x ? step_x : step_y;
      end
      MODE_RANDOMIZED: begin
        if (need_x && need_y) begin
          // Only bit 0 of the 32-bit LCG step picks the axis.
          lcg = r.rand_seed * LCG_MUL + LCG_ADD;
          return lcg[0] ? step_x : step_y;
        end
        return need_x ? step_x : step_y;
      end
      default: begin
        // West-first, north-last and odd-even all behave as XY.
        return need_x ? step_x : step_y;
      end
    endcase
  endfunction

  function automatic req_t make_route(
    input logic [COORD_W-1:0] hx, hy, tx, ty,
    input logic [LOAD_W-1:0]  le, lw, ls, ln,
    input logic [SEED_W-1:0]  seed
  );
    req_t r;
    r.here_x     = hx;
    r.here_y     = hy;
    r.target_x   = tx;
    r.target_y   = ty;
    r.east_load  = le;
    r.west_load  = lw;
    r.south_load = ls;
    r.north_load = ln;
    r.rand_seed  = seed;
    return r;
  endfunction

  // Coordinate biased toward the mesh edges.
  function automatic logic [COORD_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return COORD_MAX;
    return COORD_W'($urandom_range(MESH_DIM - 1));
  endfunction

  // Random request shaped so that arrivals, single-axis moves and load ties
  // all show up often.
  function automatic req_t random_route();
    req_t r;
    int   shape;
    r = make_route(random_coord(), random_coord(), random_coord(), random_coord(),
                   LOAD_W'($urandom), LOAD_W'($urandom), LOAD_W'($urandom),
                   LOAD_W'($urandom), SEED_W'($urandom));
    shape = $urandom_range(9);
    if (shape == 0) begin
      r.target_x = r.here_x;
      r.target_y = r.here_y;
    end else if (shape <= 2) begin
      r.target_x = r.here_x;
    end else if (shape <= 4) begin
      r.target_y = r.here_y;
    end
    if ($urandom_range(7) == 0) begin
      r.south_load = r.east_load;
      r.north_load = r.west_load;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one request, with random idle cycles ahead of it.
  task automatic send_route(input req_t r);
    @(negedge clk);
    while (!steady_traffic && $urandom_range(99) < IDLE_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.here_x     <= r.here_x;
    req_ch.here_y     <= r.here_y;
    req_ch.target_x   <= r.target_x;
    req_ch.target_y   <= r.target_y;
    req_ch.east_load  <= r.east_load;
    req_ch.west_load  <= r.west_load;
    req_ch.south_load <= r.south_load;
    req_ch.north_load <= r.north_load;
    req_ch.rand_seed  <= r.rand_seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_ports.push_back(predict_port(active_mode, r));
  endtask

  // Stop sending and hold until every predicted response has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_ports.size() != 0) @(posedge clk);
  endtask

  // Write the mode register once the block has drained.
  task automatic set_mode(input route_mode_t mode);
    wait_for_results();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= mode;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    active_mode = mode;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Corners in every mode: diagonal moves across the whole mesh with loads
  // and seeds that steer adaptive and randomized modes both ways, and an
  // arrival with every other field at its maximum.
  task automatic test_directed_modes();
    route_mode_t mode;
    mode = mode.first();
    repeat (mode.num()) begin
      // The first mode runs on the value left by reset.
      if (mode != MODE_XY) set_mode(mode);
      send_route(make_route('0, '0, COORD_MAX, COORD_MAX,
                            8'hFF, 8'h00, 8'h00, 8'hFF, 32'd1));
      send_route(make_route(COORD_MAX, COORD_MAX, '0, '0,
                            8'h00, 8'h00, 8'hFF, 8'h00, 32'd0));
      send_route(make_route(5'd5, 5'd5, 5'd5, 5'd5,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      mode = mode.next();
    end
  endtask

  // Random traffic in each mode, with a full drain halfway through.
  task automatic test_random_modes();
    route_mode_t mode;
    mode = mode.first();
    repeat (mode.num()) begin
      set_mode(mode);
      repeat (ITEMS_PER_MODE / 2) send_route(random_route());
      wait_for_results();
      repeat (ITEMS_PER_MODE / 2) send_route(random_route());
      mode = mode.next();
    end
  endtask

  // Back-to-back traffic with no gaps or stalls at the two extreme modes.
  task automatic test_back_to_back();
    steady_traffic = 1'b1;
    set_mode(MODE_RANDOMIZED);
    repeat (ITEMS_PER_MODE) send_route(random_route());
    set_mode(MODE_XY);
    repeat (ITEMS_PER_MODE) send_route(random_route());
    wait_for_results();
    steady_traffic = 1'b0;
  endtask

  // Response back-pressure.
  always @(negedge clk) begin
    rsp_ch.ready <= steady_traffic || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compare each response with the oldest prediction.
  always @(posedge clk) begin : check_responses
    port_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_ports.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected: out_port=%0d",
                                  rsp_ch.out_port));
      end else begin
        want = expected_ports.pop_front();
        if (rsp_ch.out_port !== want) begin
          report_mismatch($sformatf("out_port mismatch: got %0d, expected %0d (%s)",
                                    rsp_ch.out_port, want, want.name()));
        end
      end
    end
  end

  // Run time limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("mesh_route_compute_tb: errors");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst               = 1'b1;
    active_mode       = MODE_XY;
    mismatch_count    = 0;
    cycle_count       = 0;
    steady_traffic    = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.here_x     = '0;
    req_ch.here_y     = '0;
    req_ch.target_x   = '0;
    req_ch.target_y   = '0;
    req_ch.east_load  = '0;
    req_ch.west_load  = '0;
    req_ch.south_load = '0;
    req_ch.north_load = '0;
    req_ch.rand_seed  = '0;
    rsp_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_modes();
    test_random_modes();
    test_back_to_back();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mesh_route_compute_tb: clean");
    end else begin
      $display("mesh_route_compute_tb: errors");
    end
    $finish;
  end

endmodule
